// ===== hdl/sfr_pkg.sv =====
// Shared types and constants of the Schlick Fresnel reflectance pipeline.
// Used by the channel interfaces and by the top level; depends on nothing.
`timescale 1ns / 1ps

package sfr_pkg;

  localparam logic [15:0] ONE_Q12    = 16'd4096;
  localparam logic [15:0] REFL_ONE   = 16'd32768;
  localparam logic [16:0] ONE_Q16    = 17'd65536;
  localparam logic [30:0] ONE_Q30    = 31'h4000_0000;
  localparam int          DIV_STG    = 33;
  localparam int          R0_BITS    = 30;
  localparam int          SQ_STG     = 17;
  localparam int          POW_STG    = 4;

  typedef struct packed {
    logic signed [15:0] ray_dir_x;
    logic signed [15:0] ray_dir_y;
    logic signed [15:0] ray_dir_z;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
    logic        [15:0] refractive_index;
  } sfr_in_t;

  typedef struct packed {
    logic [15:0] reflectance;
    logic        total_internal;
  } sfr_out_t;

endpackage

// ===== hdl/sfr_if.sv =====
// Valid/ready channel interfaces for hit items and reflectance items.
// Depends on sfr_pkg for the payload types.
`timescale 1ns / 1ps

interface sfr_in_if import sfr_pkg::*; ();
  logic    valid;
  logic    ready;
  sfr_in_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface sfr_out_if import sfr_pkg::*; ();
  logic     valid;
  logic     ready;
  sfr_out_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/schlick_fresnel_reflectance.sv =====
// Schlick Fresnel reflectance unit: a 64-stage pipeline from hit item to reflectance.
// Depends on sfr_pkg and the channel interfaces in sfr_if.sv.
//
// Usage:
//   in_i carries one hit item per handshake: ray direction and normal in Q2.14 and
//   the material index in Q4.12. out_o carries one item per hit: reflectance in
//   Q1.15 and the total internal reflection flag. Items leave in arrival order.
//   From the accepting edge, an item passes through the bit-per-stage dividers
//   (33 stages, transmitted cosine and r0 side by side), the digit-per-stage
//   square root (17 stages) and 14 stages of products, powers and rounding.
//   Throughput is one item per cycle while out_o is not stalled.
//   After reset all stage valid bits are clear and out_o.valid is low.
//   When the receiver stalls with a result waiting, the whole pipeline holds and
//   in_i.ready drops; empty stages are refilled as soon as the output moves.
`timescale 1ns / 1ps

module schlick_fresnel_reflectance import sfr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  sfr_in_if.sink      in_i,
  sfr_out_if.source   out_o
);

  localparam int NST = 6 + (DIV_STG + 1) + SQ_STG + (POW_STG + 1) + 2;

  typedef struct packed {
    logic [56:0] rem1;
    logic [31:0] den1;
    logic [32:0] quo1;
    logic [61:0] rem2;
    logic [32:0] den2;
    logic [R0_BITS-1:0] quo2;
    logic        tir;
  } div_t;

  typedef struct packed {
    logic [32:0] v;
    logic [33:0] res;
    logic [R0_BITS-1:0] r0;
    logic        tir;
  } sq_t;

  typedef struct packed {
    logic [16:0] f;
    logic [16:0] p;
    logic [R0_BITS-1:0] r0;
    logic        tir;
  } tl_t;

  logic            en;
  logic [NST-1:0]  vld_q;

  assign en          = !vld_q[NST-1] || out_o.ready;
  assign in_i.ready  = en;
  assign out_o.valid = vld_q[NST-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NST-2:0], in_i.valid};
    end
  end

  // Stage 1: component products, zero index forced to one LSB
  logic signed [31:0] m0_q, m1_q, m2_q;
  logic [15:0]        n1s_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      m0_q  <= in_i.data.ray_dir_x * in_i.data.normal_x;
      m1_q  <= in_i.data.ray_dir_y * in_i.data.normal_y;
      m2_q  <= in_i.data.ray_dir_z * in_i.data.normal_z;
      n1s_q <= (in_i.data.refractive_index == 16'd0) ? 16'd1 : in_i.data.refractive_index;
    end
  end

  // Stage 2: dot product
  logic signed [33:0] dot_q;
  logic [15:0]        n2s_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      dot_q <= 34'(m0_q) + 34'(m1_q) + 34'(m2_q);
      n2s_q <= n1s_q;
    end
  end

  // Stage 3: saturated cosine, media order, index sum and difference
  logic signed [33:0] c_w;
  logic signed [33:0] negd_w;
  logic [28:0]        mag_w;
  logic               behind_w;
  logic [16:0]        a_q;
  logic [15:0]        na_q, nb_q, diff_q;
  logic [16:0]        sum_q;
  logic               test3_q;

  always_comb begin
    negd_w = -dot_q;
    if (negd_w > 34'sd268435456) begin
      c_w = 34'sd268435456;
    end else if (negd_w < -34'sd268435456) begin
      c_w = -34'sd268435456;
    end else begin
      c_w = negd_w;
    end
    behind_w = c_w[33];
    mag_w    = behind_w ? 29'(-c_w) : 29'(c_w);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_q     <= mag_w[28:12];
      na_q    <= behind_w ? n2s_q : ONE_Q12;
      nb_q    <= behind_w ? ONE_Q12 : n2s_q;
      test3_q <= behind_w ? (n2s_q > ONE_Q12) : (n2s_q < ONE_Q12);
      diff_q  <= (n2s_q > ONE_Q12) ? (n2s_q - ONE_Q12) : (ONE_Q12 - n2s_q);
      sum_q   <= {1'b0, n2s_q} + {1'b0, ONE_Q12};
    end
  end

  // Stage 4: squares
  logic [33:0] asq_w, ssq_w;
  logic [31:0] n1sq_w, n2sq_w, dsq_w;
  logic [32:0] asq_q, ssq4_q;
  logic [31:0] n1sq4_q, n2sq4_q, dsq4_q;
  logic        test4_q;

  assign asq_w  = a_q * a_q;
  assign ssq_w  = sum_q * sum_q;
  assign n1sq_w = na_q * na_q;
  assign n2sq_w = nb_q * nb_q;
  assign dsq_w  = diff_q * diff_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      asq_q   <= asq_w[32:0];
      ssq4_q  <= ssq_w[32:0];
      n1sq4_q <= n1sq_w;
      n2sq4_q <= n2sq_w;
      dsq4_q  <= dsq_w;
      test4_q <= test3_q;
    end
  end

  // Stage 5: 1 - cos^2 scaled to 2^32
  logic [32:0] q_q, ssq5_q, asq5_q;
  logic [31:0] n1sq5_q, n2sq5_q, dsq5_q;
  logic        test5_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      q_q     <= 33'h1_0000_0000 - asq_q;
      asq5_q  <= asq_q;
      ssq5_q  <= ssq4_q;
      n1sq5_q <= n1sq4_q;
      n2sq5_q <= n2sq4_q;
      dsq5_q  <= dsq4_q;
      test5_q <= test4_q;
    end
  end

  // Stage 6: both sides of the total internal reflection test
  logic [64:0] lhs_w;
  logic [63:0] lhs_q, rhs_q;
  logic [32:0] ssq6_q, asq6_q;
  logic [31:0] n2sq6_q, dsq6_q;
  logic        test6_q;

  assign lhs_w = n1sq5_q * q_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      lhs_q   <= lhs_w[63:0];
      rhs_q   <= {n2sq5_q, 32'd0};
      asq6_q  <= asq5_q;
      ssq6_q  <= ssq5_q;
      n2sq6_q <= n2sq5_q;
      dsq6_q  <= dsq5_q;
      test6_q <= test5_q;
    end
  end

  // Stage 7 loads both dividers; without the test, divide cos^2 by one so the
  // square root hands back the incidence cosine itself
  div_t        div_q [DIV_STG+1];
  logic        tir_w;
  logic [63:0] gap_w;

  assign tir_w = test6_q && (lhs_q >= rhs_q);
  assign gap_w = rhs_q - lhs_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      div_q[0].rem1 <= !test6_q ? {24'd0, asq6_q} : (tir_w ? 57'd0 : gap_w[56:0]);
      div_q[0].den1 <= test6_q ? n2sq6_q : 32'd1;
      div_q[0].quo1 <= '0;
      div_q[0].rem2 <= {dsq6_q, 30'd0};
      div_q[0].den2 <= ssq6_q;
      div_q[0].quo2 <= '0;
      div_q[0].tir  <= tir_w;
    end
  end

  // Restoring division, one quotient bit per stage, MSB first
  for (genvar k = 1; k <= DIV_STG; k++) begin : g_div
    localparam int B = DIV_STG - k;
    div_t        nx;
    logic [64:0] t1;
    logic [62:0] t2;

    always_comb begin
      nx = div_q[k-1];
      t1 = 65'(div_q[k-1].den1) << B;
      t2 = 63'(div_q[k-1].den2) << B;
      if ({8'd0, div_q[k-1].rem1} >= t1) begin
        nx.rem1    = div_q[k-1].rem1 - t1[56:0];
        nx.quo1[B] = 1'b1;
      end
      if (B < R0_BITS) begin
        if ({1'b0, div_q[k-1].rem2} >= t2) begin
          nx.rem2                        = div_q[k-1].rem2 - t2[61:0];
          nx.quo2[B % R0_BITS] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        div_q[k] <= nx;
      end
    end
  end

  // Integer square root of the transmitted cosine squared, one digit per stage
  sq_t sq_in;
  sq_t sq_q [SQ_STG];

  always_comb begin
    sq_in.v   = div_q[DIV_STG].quo1;
    sq_in.res = '0;
    sq_in.r0  = div_q[DIV_STG].quo2;
    sq_in.tir = div_q[DIV_STG].tir;
  end

  for (genvar k = 0; k < SQ_STG; k++) begin : g_sq
    localparam int B = 2 * (SQ_STG - 1 - k);
    sq_t         src;
    sq_t         nx;
    logic [33:0] bit_v;
    logic [33:0] t;

    if (k == 0) begin : g_first
      assign src = sq_in;
    end else begin : g_next
      assign src = sq_q[k-1];
    end

    always_comb begin
      nx    = src;
      bit_v = 34'd1 << B;
      t     = src.res + bit_v;
      if ({1'b0, src.v} >= t) begin
        nx.v   = src.v - t[32:0];
        nx.res = (src.res >> 1) + bit_v;
      end else begin
        nx.res = src.res >> 1;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        sq_q[k] <= nx;
      end
    end
  end

  // Fifth power of (1 - cos), truncated to Q1.16 after each product
  tl_t         tl_q [POW_STG+1];
  logic [16:0] cos_w;

  assign cos_w = (sq_q[SQ_STG-1].res > 34'(ONE_Q16)) ? ONE_Q16 : sq_q[SQ_STG-1].res[16:0];

  always_ff @(posedge clk_i) begin
    if (en) begin
      tl_q[0].f   <= ONE_Q16 - cos_w;
      tl_q[0].p   <= ONE_Q16 - cos_w;
      tl_q[0].r0  <= sq_q[SQ_STG-1].r0;
      tl_q[0].tir <= sq_q[SQ_STG-1].tir;
    end
  end

  for (genvar k = 1; k <= POW_STG; k++) begin : g_pow
    logic [33:0] pf;

    assign pf = tl_q[k-1].p * tl_q[k-1].f;

    always_ff @(posedge clk_i) begin
      if (en) begin
        tl_q[k].f   <= tl_q[k-1].f;
        tl_q[k].p   <= pf[32:16];
        tl_q[k].r0  <= tl_q[k-1].r0;
        tl_q[k].tir <= tl_q[k-1].tir;
      end
    end
  end

  // Scale the power by 1 - r0
  logic [47:0]        prod_w;
  logic [47:0]        prod_q;
  logic [R0_BITS-1:0] r0_q;
  logic               tir_q;

  assign prod_w = (ONE_Q30 - 31'(tl_q[POW_STG].r0)) * tl_q[POW_STG].p;

  always_ff @(posedge clk_i) begin
    if (en) begin
      prod_q <= prod_w;
      r0_q   <= tl_q[POW_STG].r0;
      tir_q  <= tl_q[POW_STG].tir;
    end
  end

  // Add r0, round to Q1.15, saturate at one; total internal reflection gives one
  logic [32:0] rsum_w;
  logic [17:0] rnd_w;
  sfr_out_t    out_q;

  assign rsum_w = 33'(r0_q) + 33'(prod_q[47:16]) + 33'd16384;
  assign rnd_w  = rsum_w[32:15];

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (tir_q) begin
        out_q.reflectance    <= REFL_ONE;
        out_q.total_internal <= 1'b1;
      end else begin
        out_q.reflectance    <= (rnd_w > 18'(REFL_ONE)) ? REFL_ONE : rnd_w[15:0];
        out_q.total_internal <= 1'b0;
      end
    end
  end

  assign out_o.data = out_q;

endmodule

// ===== hdl/sfr_checker.sv =====
// Port-level checks of the Schlick Fresnel reflectance unit, bound to the top level.
// Depends on sfr_pkg and on the top level's channel ports.
`timescale 1ns / 1ps

module sfr_checker import sfr_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [15:0] reflectance_i,
  input logic        total_internal_i
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(reflectance_i) && $stable(total_internal_i))
    else $error("stalled result changed");

  a_tir_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && total_internal_i |-> reflectance_i == REFL_ONE)
    else $error("total internal reflection without full reflectance");

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> reflectance_i <= REFL_ONE)
    else $error("reflectance above one");

endmodule

bind schlick_fresnel_reflectance sfr_checker u_sfr_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_i      (out_o.valid),
  .out_ready_i      (out_o.ready),
  .reflectance_i    (out_o.data.reflectance),
  .total_internal_i (out_o.data.total_internal)
);
